// ===== hw/rtl/acceleration_run_timer_defines.svh =====
// Assertion helpers for the checker file.
`ifndef ACCELERATION_RUN_TIMER_DEFINES_SVH
`define ACCELERATION_RUN_TIMER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted
`define ART_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define ART_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/art_pkg.sv =====
`default_nettype none

package art_pkg;

    // Field widths
    localparam int SPEED_W  = 13;
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 20;
    localparam int LEAD_W   = 10;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Stream words: data fields packed from bit 0, padded to whole bytes
    localparam int IN_FIELDS_W  = SPEED_W + 3 * TIME_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * TIME_W + 2 * STATUS_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Register file
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [2:0] REG_START_SPEED   = 3'd0;
    localparam logic [2:0] REG_MID_SPEED     = 3'd1;
    localparam logic [2:0] REG_END_SPEED     = 3'd2;
    localparam logic [2:0] REG_FIRST_LIMIT   = 3'd3;
    localparam logic [2:0] REG_SECOND_LIMIT  = 3'd4;
    localparam logic [2:0] REG_START_LEAD    = 3'd5;
    localparam logic [2:0] REG_FIRST_DEFAULT = 3'd6;
    localparam logic [2:0] REG_SECOND_DEFAULT = 3'd7;

    // Reset values
    localparam logic [SPEED_W-1:0] START_SPEED_RST    = 13'd1;
    localparam logic [SPEED_W-1:0] MID_SPEED_RST      = 13'd1600;
    localparam logic [SPEED_W-1:0] END_SPEED_RST      = 13'd3200;
    localparam logic [LIMIT_W-1:0] FIRST_LIMIT_RST    = 20'd20000;
    localparam logic [LIMIT_W-1:0] SECOND_LIMIT_RST   = 20'd40000;
    localparam logic [LEAD_W-1:0]  START_LEAD_RST     = 10'd10;
    localparam logic [LIMIT_W-1:0] FIRST_DEFAULT_RST  = 20'd20001;
    localparam logic [LIMIT_W-1:0] SECOND_DEFAULT_RST = 20'd40001;
    localparam logic [TIME_W-1:0]  FIRST_TIME_RST     = 32'd20001;
    localparam logic [TIME_W-1:0]  SECOND_TIME_RST    = 32'd40001;

    typedef enum logic [STATUS_W-1:0] {
        RUN_IDLE     = 2'd0,
        RUN_ACTIVE   = 2'd1,
        RUN_COMPLETE = 2'd2,
        RUN_MISSED   = 2'd3
    } run_status_t;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE     = 2'd0,
        OP_LOAD_BEST  = 2'd1,
        OP_RESET_BEST = 2'd2
    } op_t;

    // State of one timed run
    typedef struct packed {
        run_status_t       status;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] best;
    } run_t;

    typedef struct packed {
        run_t run;
        logic improved;
    } run_upd_t;

    // One sample applied to one run: optional (re)start, then evaluation
    function automatic run_upd_t run_update(
        input run_t               cur,
        input logic               start_hit,
        input logic               reached,
        input logic [LIMIT_W-1:0] limit,
        input logic [LEAD_W-1:0]  lead,
        input logic [TIME_W-1:0]  now
    );
        logic [TIME_W-1:0] lead_ext;
        logic [TIME_W-1:0] elapsed;
        run_upd_t          r;
        lead_ext   = {{(TIME_W-LEAD_W){1'b0}}, lead};
        r.run      = cur;
        r.improved = 1'b0;
        // A fresh start gives now - start directly: the lead, or now when floored
        if (start_hit) begin
            r.run.status = RUN_ACTIVE;
            if (now >= lead_ext) begin
                r.run.start = now - lead_ext;
                elapsed     = lead_ext;
            end else begin
                r.run.start = '0;
                elapsed     = now;
            end
        end else begin
            elapsed = now - cur.start;
        end
        if (r.run.status == RUN_ACTIVE) begin
            r.run.elapsed = elapsed;
            if (reached) begin
                r.run.status = RUN_COMPLETE;
                if (elapsed < cur.best) begin
                    r.run.best = elapsed;
                    r.improved = 1'b1;
                end
            end else if (elapsed > {{(TIME_W-LIMIT_W){1'b0}}, limit}) begin
                r.run.status = RUN_MISSED;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/acceleration_run_timer.sv =====
// Path: a result word reaches m_tdata through the input word register and then
//   the output word register, and waits there while a low m_tready holds it.
// Throughput: one word per cycle while a low m_tready does not stall the output; the
//   run state updates combinationally from the input register into the output register.
// Reset: synchronous, active low; clears run state, best times and
//   registers to their defaults and empties both word registers.
`default_nettype none

module acceleration_run_timer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // speed[12:0], now_ms[44:13], load_first_best[76:45],
    // load_second_best[108:77], zero pad
    input  wire logic [art_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  wire logic [art_pkg::OP_W-1:0]        s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // first_time_ms[31:0], first_status[33:32], second_time_ms[65:34],
    // second_status[67:66], first_best_ms[99:68], second_best_ms[131:100],
    // best_changed[132], zero pad
    output logic [art_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // Register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [art_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [art_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [art_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int SW = art_pkg::SPEED_W;
    localparam int TW = art_pkg::TIME_W;
    localparam int LW = art_pkg::LIMIT_W;
    localparam int DW = art_pkg::LEAD_W;

    // Registers
    logic [SW-1:0] start_speed_reg, mid_speed_reg, end_speed_reg;
    logic [LW-1:0] first_limit_reg, second_limit_reg;
    logic [DW-1:0] start_lead_reg;
    logic [LW-1:0] first_default_reg, second_default_reg;

    // Input word register
    logic                      in_valid_reg;
    logic [art_pkg::OP_W-1:0]  op_reg;
    logic [SW-1:0]             speed_reg;
    logic [TW-1:0]             now_reg;
    logic [TW-1:0]             load_first_reg;
    logic [TW-1:0]             load_second_reg;

    // Timer state
    logic [SW-1:0]  prev_speed_reg, prev_speed_next;
    art_pkg::run_t  first_reg, first_next;
    art_pkg::run_t  second_reg, second_next;
    logic           changed_reg, changed_next;

    // Output word register
    logic                         out_valid_reg;
    logic [art_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic advance;
    logic cfg_write;
    art_pkg::run_upd_t first_upd, second_upd;

    // Handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_speed_reg    <= art_pkg::START_SPEED_RST;
            mid_speed_reg      <= art_pkg::MID_SPEED_RST;
            end_speed_reg      <= art_pkg::END_SPEED_RST;
            first_limit_reg    <= art_pkg::FIRST_LIMIT_RST;
            second_limit_reg   <= art_pkg::SECOND_LIMIT_RST;
            start_lead_reg     <= art_pkg::START_LEAD_RST;
            first_default_reg  <= art_pkg::FIRST_DEFAULT_RST;
            second_default_reg <= art_pkg::SECOND_DEFAULT_RST;
        end else if (cfg_write) begin
            case (paddr[4:2])
                art_pkg::REG_START_SPEED:    start_speed_reg    <= pwdata[SW-1:0];
                art_pkg::REG_MID_SPEED:      mid_speed_reg      <= pwdata[SW-1:0];
                art_pkg::REG_END_SPEED:      end_speed_reg      <= pwdata[SW-1:0];
                art_pkg::REG_FIRST_LIMIT:    first_limit_reg    <= pwdata[LW-1:0];
                art_pkg::REG_SECOND_LIMIT:   second_limit_reg   <= pwdata[LW-1:0];
                art_pkg::REG_START_LEAD:     start_lead_reg     <= pwdata[DW-1:0];
                art_pkg::REG_FIRST_DEFAULT:  first_default_reg  <= pwdata[LW-1:0];
                art_pkg::REG_SECOND_DEFAULT: second_default_reg <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            art_pkg::REG_START_SPEED:    prdata = {{(32-SW){1'b0}}, start_speed_reg};
            art_pkg::REG_MID_SPEED:      prdata = {{(32-SW){1'b0}}, mid_speed_reg};
            art_pkg::REG_END_SPEED:      prdata = {{(32-SW){1'b0}}, end_speed_reg};
            art_pkg::REG_FIRST_LIMIT:    prdata = {{(32-LW){1'b0}}, first_limit_reg};
            art_pkg::REG_SECOND_LIMIT:   prdata = {{(32-LW){1'b0}}, second_limit_reg};
            art_pkg::REG_START_LEAD:     prdata = {{(32-DW){1'b0}}, start_lead_reg};
            art_pkg::REG_FIRST_DEFAULT:  prdata = {{(32-LW){1'b0}}, first_default_reg};
            art_pkg::REG_SECOND_DEFAULT: prdata = {{(32-LW){1'b0}}, second_default_reg};
            default:                     prdata = '0;
        endcase
    end

    // Input word capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg          <= s_tuser;
            speed_reg       <= s_tdata[12:0];
            now_reg         <= s_tdata[44:13];
            load_first_reg  <= s_tdata[76:45];
            load_second_reg <= s_tdata[108:77];
        end
    end

    // Run evaluation for a speed sample
    assign first_upd = art_pkg::run_update(
        first_reg,
        (prev_speed_reg < start_speed_reg) && (speed_reg >= start_speed_reg),
        speed_reg >= mid_speed_reg,
        first_limit_reg, start_lead_reg, now_reg);

    assign second_upd = art_pkg::run_update(
        second_reg,
        (prev_speed_reg <= mid_speed_reg) && (speed_reg > mid_speed_reg),
        speed_reg >= end_speed_reg,
        second_limit_reg, start_lead_reg, now_reg);

    // Next state by operation
    always_comb begin
        prev_speed_next = prev_speed_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        changed_next    = changed_reg;
        case (art_pkg::op_t'(op_reg))
            art_pkg::OP_SAMPLE: begin
                prev_speed_next = speed_reg;
                first_next      = first_upd.run;
                second_next     = second_upd.run;
                changed_next    = changed_reg | first_upd.improved | second_upd.improved;
            end
            art_pkg::OP_LOAD_BEST: begin
                first_next.best  = load_first_reg;
                second_next.best = load_second_reg;
                changed_next     = 1'b0;
            end
            art_pkg::OP_RESET_BEST: begin
                first_next.best  = {{(TW-LW){1'b0}}, first_default_reg};
                second_next.best = {{(TW-LW){1'b0}}, second_default_reg};
                changed_next     = 1'b1;
            end
            default: ;
        endcase
    end

    // Result word from the updated state
    always_comb begin
        out_data_next = '0;
        out_data_next[art_pkg::OUT_FIELDS_W-1:0] = {
            changed_next,
            second_next.best,
            first_next.best,
            second_next.status,
            second_next.elapsed,
            first_next.status,
            first_next.elapsed
        };
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_speed_reg     <= '0;
            first_reg.status   <= art_pkg::RUN_IDLE;
            first_reg.start    <= '0;
            first_reg.elapsed  <= art_pkg::FIRST_TIME_RST;
            first_reg.best     <= art_pkg::FIRST_TIME_RST;
            second_reg.status  <= art_pkg::RUN_IDLE;
            second_reg.start   <= '0;
            second_reg.elapsed <= art_pkg::SECOND_TIME_RST;
            second_reg.best    <= art_pkg::SECOND_TIME_RST;
            changed_reg        <= 1'b0;
        end else if (advance) begin
            prev_speed_reg <= prev_speed_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            changed_reg    <= changed_next;
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/art_checker.sv =====
`default_nettype none

`include "acceleration_run_timer_defines.svh"

module art_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [art_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // No result word survives reset
    `ART_ASSERT_NEXT_RST(a_reset_empty, !aresetn, !m_tvalid, "result word valid after reset")

    // A stalled result word holds
    `ART_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "stalled result word changed")

    // An empty output side never blocks the input
    `ART_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "input blocked with output empty")

    // An accepted word reaches an empty output side through the input and output registers
    `ART_ASSERT_NEXT(a_latency, s_tvalid && s_tready && !m_tvalid, ##1 m_tvalid,
        "result word missing two cycles after input")

endmodule

bind acceleration_run_timer art_checker u_art_checker (.*);

`default_nettype wire
